### rtl/ccd_pkg.sv
// Shared types, format codes and character constants of the cheat code decoder.
// Used by every module of the block; depends on nothing.
package ccd_pkg;

    // Character slots that any recognized format can reach.
    localparam int CODE_SLOTS = 12;

    typedef logic [7:0] char_t;
    typedef logic [3:0] fmt_t;

    // Result format codes.
    localparam fmt_t FMT_CON_SUB    = 4'd0;
    localparam fmt_t FMT_CON_REPLAY = 4'd1;
    localparam fmt_t FMT_CON_PLAIN  = 4'd2;
    localparam fmt_t FMT_CON_CMP    = 4'd3;
    localparam fmt_t FMT_HH_SUB6    = 4'd4;
    localparam fmt_t FMT_HH_SUB9    = 4'd5;
    localparam fmt_t FMT_HH_BSWAP   = 4'd6;
    localparam fmt_t FMT_HH_PLAIN   = 4'd7;
    localparam fmt_t FMT_HH_CMP     = 4'd8;
    // Internal code for a length or separator pattern that matches no format.
    localparam fmt_t FMT_NONE       = 4'd15;

    localparam char_t CH_DASH  = 8'h2d;
    localparam char_t CH_EQ    = 8'h3d;
    localparam char_t CH_QUEST = 8'h3f;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_ONE   = 8'h31;

    localparam logic [7:0] CMP_XOR = 8'hba;

    // Letter substitution alphabet: entry i is the character that stands for digit i.
    localparam char_t SUBST [16] = '{
        8'h64, 8'h66, 8'h34, 8'h37, 8'h30, 8'h39, 8'h31, 8'h35,
        8'h36, 8'h62, 8'h63, 8'h38, 8'h61, 8'h32, 8'h33, 8'h65
    };

    // Source bit of the substitution word for address bit 23 down to 0.
    localparam logic [4:0] PERM_SRC [24] = '{
        5'd13, 5'd12, 5'd11, 5'd10, 5'd5,  5'd4,  5'd3,  5'd2,
        5'd23, 5'd22, 5'd21, 5'd20, 5'd1,  5'd0,  5'd15, 5'd14,
        5'd19, 5'd18, 5'd17, 5'd16, 5'd9,  5'd8,  5'd7,  5'd6
    };

    // One classified code on its way from the front end to the decoder.
    typedef struct packed {
        fmt_t                     fmt;
        char_t [CODE_SLOTS-1:0]   chars;
        logic                     handheld;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_req_t;

    // Hex digit value; bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_val(input char_t c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b0, c[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        else
        begin
            r = 5'd16;
        end
        return r;
    endfunction

    // Substitution digit value; bit 4 set means the letter is not in the alphabet.
    function automatic logic [4:0] subst_val(input char_t c);
        logic [4:0] r;
        r = 5'd16;
        for (int i = 0; i < 16; i++)
        begin
            if (SUBST[i] == c)
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

### rtl/ccd_in_if.sv
// Character request channel of the cheat code decoder: valid, ready, one character and its last flag.
// Depends on nothing.
interface ccd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_char;
    logic       last_char;

    modport source (output valid, code_char, last_char, input ready);
    modport sink   (input valid, code_char, last_char, output ready);
endinterface

### rtl/ccd_out_if.sv
// Result request channel of the cheat code decoder: valid, ready and one decoded code.
// Depends on nothing.
interface ccd_out_if;
    logic        valid;
    logic        ready;
    logic        code_valid;
    logic [3:0]  code_format;
    logic [23:0] target_address;
    logic        has_compare;
    logic [7:0]  compare_byte;
    logic [7:0]  data_byte;

    modport source (output valid, code_valid, code_format, target_address, has_compare,
                    compare_byte, data_byte, input ready);
    modport sink   (input valid, code_valid, code_format, target_address, has_compare,
                    compare_byte, data_byte, output ready);
endinterface

### rtl/ccd_front.sv
// Front end: takes characters, buffers them and classifies a finished code by layout.
// Depends on ccd_pkg and ccd_in_if.
module ccd_front #(
    parameter int MAX_CODE_CHARS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    ccd_in_if.sink             in_ch,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               q_full,
    output ccd_pkg::job_req_t  push
);

    localparam int CNT_W = $clog2(MAX_CODE_CHARS + 2);
    localparam int IDX_W = $clog2(MAX_CODE_CHARS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CODE_CHARS);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_CODE_CHARS + 1);

    ccd_pkg::char_t                            buf_reg [MAX_CODE_CHARS];
    logic [CNT_W-1:0]                          count_reg, count_next;
    logic                                      handheld_reg;
    logic                                      accept;
    logic                                      have_room;
    logic [CNT_W-1:0]                          len;
    ccd_pkg::char_t [ccd_pkg::CODE_SLOTS-1:0]  chars_now;
    ccd_pkg::fmt_t                             fmt;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign have_room   = count_reg < CNT_MAX;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (in_ch.last_char)
            begin
                count_next = '0;
            end
            else if (have_room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                count_next = CNT_OVER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            handheld_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                handheld_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && have_room)
        begin
            buf_reg[count_reg[IDX_W-1:0]] <= in_ch.code_char;
        end
    end

    // The code as it stands including the character arriving now.
    always_comb
    begin
        for (int i = 0; i < ccd_pkg::CODE_SLOTS; i++)
        begin
            chars_now[i] = (have_room && count_reg == CNT_W'(i)) ? in_ch.code_char
                                                                 : buf_reg[i];
        end
        len = have_room ? count_reg + CNT_W'(1) : CNT_OVER;
    end

    // Layout match in priority order; digits are checked later.
    always_comb
    begin
        fmt = ccd_pkg::FMT_NONE;
        if (!handheld_reg)
        begin
            if (len == CNT_W'(9) && chars_now[4] == ccd_pkg::CH_DASH)
            begin
                fmt = ccd_pkg::FMT_CON_SUB;
            end
            else if (len == CNT_W'(8))
            begin
                fmt = ccd_pkg::FMT_CON_REPLAY;
            end
            else if (len == CNT_W'(9) && chars_now[6] == ccd_pkg::CH_EQ)
            begin
                fmt = ccd_pkg::FMT_CON_PLAIN;
            end
            else if (len == CNT_W'(12) && chars_now[6] == ccd_pkg::CH_EQ
                     && chars_now[9] == ccd_pkg::CH_QUEST)
            begin
                fmt = ccd_pkg::FMT_CON_CMP;
            end
        end
        else
        begin
            if (len == CNT_W'(7) && chars_now[3] == ccd_pkg::CH_DASH)
            begin
                fmt = ccd_pkg::FMT_HH_SUB6;
            end
            else if (len == CNT_W'(11) && chars_now[3] == ccd_pkg::CH_DASH
                     && chars_now[7] == ccd_pkg::CH_DASH)
            begin
                fmt = ccd_pkg::FMT_HH_SUB9;
            end
            else if (len == CNT_W'(8))
            begin
                fmt = ccd_pkg::FMT_HH_BSWAP;
            end
            else if (len == CNT_W'(7) && chars_now[4] == ccd_pkg::CH_EQ)
            begin
                fmt = ccd_pkg::FMT_HH_PLAIN;
            end
            else if (len == CNT_W'(10) && chars_now[4] == ccd_pkg::CH_EQ
                     && chars_now[7] == ccd_pkg::CH_QUEST)
            begin
                fmt = ccd_pkg::FMT_HH_CMP;
            end
        end
    end

    assign push.valid        = accept && in_ch.last_char;
    assign push.job.fmt      = fmt;
    assign push.job.chars    = chars_now;
    assign push.job.handheld = handheld_reg;

`ifndef SYNTHESIS
    // A finished code always restarts the character count.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.last_char |=> count_reg == '0)
        else $error("character count not cleared after last character");
`endif

endmodule

### rtl/ccd_queue.sv
// Two-entry queue of classified codes between the front end and the decoder.
// Depends on ccd_pkg.
module ccd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ccd_pkg::job_req_t  push,
    input  logic               pop,
    output logic               full,
    output ccd_pkg::job_req_t  head
);

    ccd_pkg::job_t q_mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg, cnt_next;

    assign full       = cnt_reg == 2'd2;
    assign head.valid = cnt_reg != 2'd0;
    assign head.job   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            q_mem_reg[wr_ptr_reg] <= push.job;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue occupancy above its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("queue popped while empty");
`endif

endmodule

### rtl/ccd_back.sv
// Back end: checks digits, decodes a classified code and holds the result register.
// Depends on ccd_pkg and ccd_out_if.
module ccd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ccd_pkg::job_req_t  head,
    output logic               pop,
    ccd_out_if.source          out_ch
);

    // Character positions that must be hex digits, per format; the replay mask also serves the byte-swap format.
    localparam logic [11:0] MASK_REPLAY    = 12'h0ff;
    localparam logic [11:0] MASK_CON_PLAIN = 12'h1bf;
    localparam logic [11:0] MASK_CON_CMP   = 12'hdbf;
    localparam logic [11:0] MASK_HH_SUB6   = 12'h077;
    localparam logic [11:0] MASK_HH_SUB9   = 12'h777;
    localparam logic [11:0] MASK_HH_PLAIN  = 12'h06f;
    localparam logic [11:0] MASK_HH_CMP    = 12'h36f;

    typedef struct packed {
        logic        code_valid;
        logic [3:0]  code_format;
        logic [23:0] target_address;
        logic        has_compare;
        logic [7:0]  compare_byte;
        logic [7:0]  data_byte;
    } res_t;

    res_t        res, res_reg;
    logic        out_valid_reg;
    logic [3:0]  nib [12];
    logic [11:0] bad;
    logic [31:0] sub_word;
    logic        sub_bad;
    logic [23:0] sub_addr;
    logic        ok;

    assign pop = head.valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        logic [4:0] hv;
        logic [4:0] sv;
        for (int i = 0; i < 12; i++)
        begin
            hv     = ccd_pkg::hex_val(head.job.chars[i]);
            nib[i] = hv[3:0];
            bad[i] = hv[4];
        end
        // Substitution word from the eight letters around the dash.
        sub_word = '0;
        sub_bad  = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            sv       = ccd_pkg::subst_val(head.job.chars[(k < 4) ? k : k + 1]);
            sub_bad  = sub_bad | sv[4];
            sub_word = {sub_word[27:0], sv[3:0]};
        end
        for (int i = 0; i < 24; i++)
        begin
            sub_addr[23 - i] = sub_word[ccd_pkg::PERM_SRC[i]];
        end
    end

    always_comb
    begin
        res             = '0;
        res.code_format = head.job.fmt;
        ok              = 1'b0;
        unique case (head.job.fmt)
            ccd_pkg::FMT_CON_SUB:
            begin
                ok                 = !sub_bad;
                res.target_address = sub_addr;
                res.data_byte      = sub_word[31:24];
            end
            ccd_pkg::FMT_CON_REPLAY:
            begin
                ok                 = ~|(bad & MASK_REPLAY);
                res.target_address = {nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
                res.data_byte      = {nib[6], nib[7]};
            end
            ccd_pkg::FMT_CON_PLAIN:
            begin
                ok                 = ~|(bad & MASK_CON_PLAIN);
                res.target_address = {nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
                res.data_byte      = {nib[7], nib[8]};
            end
            ccd_pkg::FMT_CON_CMP:
            begin
                ok                 = ~|(bad & MASK_CON_CMP);
                res.target_address = {nib[0], nib[1], nib[2], nib[3], nib[4], nib[5]};
                res.has_compare    = 1'b1;
                res.compare_byte   = {nib[7], nib[8]};
                res.data_byte      = {nib[10], nib[11]};
            end
            ccd_pkg::FMT_HH_SUB6:
            begin
                ok                 = ~|(bad & MASK_HH_SUB6);
                res.target_address = {8'h00, ~nib[6], nib[2], nib[4], nib[5]};
                res.data_byte      = {nib[0], nib[1]};
            end
            ccd_pkg::FMT_HH_SUB9:
            begin
                ok                 = ~|(bad & MASK_HH_SUB9);
                res.target_address = {8'h00, ~nib[6], nib[2], nib[4], nib[5]};
                res.data_byte      = {nib[0], nib[1]};
                res.has_compare    = 1'b1;
                // Compare byte: digits seven and nine, rotated right by two.
                res.compare_byte   = {nib[10][1:0], nib[8], nib[10][3:2]}
                                     ^ ccd_pkg::CMP_XOR;
            end
            ccd_pkg::FMT_HH_BSWAP:
            begin
                ok                 = ~|(bad & MASK_REPLAY)
                                     && head.job.chars[0] == ccd_pkg::CH_ZERO
                                     && head.job.chars[1] == ccd_pkg::CH_ONE;
                res.data_byte      = {nib[2], nib[3]};
                res.target_address = {8'h00, nib[6], nib[7], nib[4], nib[5]};
            end
            ccd_pkg::FMT_HH_PLAIN:
            begin
                ok                 = ~|(bad & MASK_HH_PLAIN);
                res.target_address = {8'h00, nib[0], nib[1], nib[2], nib[3]};
                res.data_byte      = {nib[5], nib[6]};
            end
            ccd_pkg::FMT_HH_CMP:
            begin
                ok                 = ~|(bad & MASK_HH_CMP);
                res.target_address = {8'h00, nib[0], nib[1], nib[2], nib[3]};
                res.has_compare    = 1'b1;
                res.compare_byte   = {nib[5], nib[6]};
                res.data_byte      = {nib[8], nib[9]};
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (ok)
        begin
            res.code_valid = 1'b1;
        end
        else
        begin
            res = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.code_valid     = res_reg.code_valid;
    assign out_ch.code_format    = res_reg.code_format;
    assign out_ch.target_address = res_reg.target_address;
    assign out_ch.has_compare    = res_reg.has_compare;
    assign out_ch.compare_byte   = res_reg.compare_byte;
    assign out_ch.data_byte      = res_reg.data_byte;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.code_valid |->
            out_ch.code_format == 4'd0 && out_ch.target_address == 24'd0
            && !out_ch.has_compare && out_ch.compare_byte == 8'd0
            && out_ch.data_byte == 8'd0)
        else $error("rejected code carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.has_compare |->
            out_ch.code_format == ccd_pkg::FMT_CON_CMP
            || out_ch.code_format == ccd_pkg::FMT_HH_SUB9
            || out_ch.code_format == ccd_pkg::FMT_HH_CMP)
        else $error("compare flag on a format without a compare byte");
`endif

endmodule

### rtl/cheat_code_decoder.sv
// Top level of the cheat code decoder: front end, code queue and decoder back end.
// Depends on ccd_pkg, ccd_in_if, ccd_out_if, ccd_front, ccd_queue and ccd_back.
//
//   Channel   Direction  Handshake          Contents
//   in_ch     in         valid / ready      code_char, last_char (one character per request)
//   out_ch    out        valid / ready      code_valid, code_format, target_address,
//                                           has_compare, compare_byte, data_byte
//   cfg       in         cfg_wr_en          cfg_wr_data = handheld_target
//
// One character is taken per cycle while in_ch.ready is high. A code's result passes
// from the request that carries its last character into the queue and then into
// the result register that drives out_ch. Reset clears the character count, the target select,
// the queue pointers and the result valid; the character buffer keeps stale data.
// in_ch.ready drops only while the two-entry queue holds two finished codes, which
// happens when out_ch has been stalled; non-final characters also wait then.
module cheat_code_decoder #(
    parameter int MAX_CODE_CHARS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    ccd_in_if.sink      in_ch,
    ccd_out_if.source   out_ch,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    // Classified codes leaving the front end, and the head of the queue.
    ccd_pkg::job_req_t push;
    ccd_pkg::job_req_t head;
    logic              q_full;
    logic              pop;

    // The front end buffers characters and, on the last one, picks the format from
    // the length and separator positions. The buffered characters go along with it.
    ccd_front #(
        .MAX_CODE_CHARS (MAX_CODE_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .push        (push)
    );

    // The queue lets the front end keep taking characters while a result waits.
    ccd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // The back end checks the hex digits, undoes the substitutions and permutations
    // and registers the result for out_ch.
    ccd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
